// ===== rtl/sd_spi_init_and_block_read_assert.svh =====
// Assertion macros used by the top RTL file of the SD SPI host.
`ifndef SD_SPI_INIT_AND_BLOCK_READ_ASSERT_SVH
`define SD_SPI_INIT_AND_BLOCK_READ_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define SDSPI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define SDSPI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sdspi_pkg.sv =====
`timescale 1ns / 1ps
package sdspi_pkg;

  // Sequencer phases.
  typedef enum logic [4:0] {
    PH_IDLE,
    PH_DUMMY,
    PH_FRAME,
    PH_RESP,
    PH_TAIL,
    PH_TOKEN,
    PH_DATA
  } phase_t;

  // Input word commands.
  localparam logic [1:0] REQ_BYTE = 2'd0;
  localparam logic [1:0] REQ_INIT = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;

  // Finish status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ERR     = 2'd1;
  localparam logic [1:0] ST_TIMEOUT = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_DUMMY_BYTES    = 3'd0;
  localparam logic [2:0] CFG_RESET_ATTEMPTS = 3'd1;
  localparam logic [2:0] CFG_INIT_ATTEMPTS  = 3'd2;
  localparam logic [2:0] CFG_RESPONSE_POLLS = 3'd3;
  localparam logic [2:0] CFG_TOKEN_POLLS    = 3'd4;

  // SD command indexes.
  localparam logic [5:0] CMD_GO_IDLE  = 6'd0;
  localparam logic [5:0] CMD_BLOCKLEN = 6'd16;
  localparam logic [5:0] CMD_READ     = 6'd17;
  localparam logic [5:0] CMD_OP_COND  = 6'd41;
  localparam logic [5:0] CMD_APP      = 6'd55;

  // Bytes and sizes of the protocol.
  localparam logic [7:0]  BYTE_IDLE     = 8'hFF;
  localparam logic [7:0]  TOKEN_START   = 8'hFE;
  localparam logic [7:0]  FRAME_START   = 8'h40;
  localparam logic [7:0]  CRC_GO_IDLE   = 8'h95;
  localparam logic [7:0]  CRC_OTHER     = 8'h01;
  localparam logic [31:0] BLOCKLEN_ARG  = 32'd512;
  localparam int          BLOCK_BYTES   = 512;
  localparam int          BC_W          = $clog2(BLOCK_BYTES + 2) + 1;
  localparam logic [BC_W-1:0] FRAME_BYTES = BC_W'(8);
  localparam logic [BC_W-1:0] DATA_END    = BC_W'(BLOCK_BYTES);
  localparam logic [BC_W-1:0] BLOCK_END   = BC_W'(BLOCK_BYTES + 2);

  // Command state seen by the frame generator.
  typedef struct packed {
    phase_t          phase;
    logic [BC_W-1:0] byte_count;
    logic [5:0]      index;
    logic [31:0]     arg;
  } cmd_state_t;

  // One requested SPI exchange.
  typedef struct packed {
    logic [7:0] mosi;
    logic       select;
  } xfer_t;

  // One result word.
  typedef struct packed {
    logic       xfer;
    logic [7:0] mosi;
    logic       select;
    logic       data_valid;
    logic [7:0] data_byte;
    logic       done_res;
    logic [1:0] status;
  } res_t;

endpackage

// ===== rtl/sdspi_if.sv =====
`timescale 1ns / 1ps
// Input channel: command words and returned MISO bytes.
interface sdspi_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [22:0] lba;
  logic [7:0]  miso;

  modport source (output valid, command, lba, miso, input ready);
  modport sink (input valid, command, lba, miso, output ready);
endinterface

// Result channel: exchange requests, block data and finish reports.
interface sdspi_out_if;
  logic       valid;
  logic       ready;
  logic       xfer;
  logic [7:0] mosi;
  logic       select;
  logic       data_valid;
  logic [7:0] data_byte;
  logic       done_res;
  logic [1:0] status;

  modport source (output valid, xfer, mosi, select, data_valid, data_byte, done_res,
                  status, input ready);
  modport sink (input valid, xfer, mosi, select, data_valid, data_byte, done_res,
                status, output ready);
endinterface

// ===== rtl/sdspi_frame_gen.sv =====
`timescale 1ns / 1ps
module sdspi_frame_gen
  import sdspi_pkg::*;
(
  input  cmd_state_t cs,
  output xfer_t      xo
);

  // Byte to send and chip select level for the current phase and position.
  always_comb begin
    xo.mosi   = BYTE_IDLE;
    xo.select = 1'b1;
    case (cs.phase)
      PH_DUMMY, PH_TAIL: begin
        xo.select = 1'b0;
      end
      PH_FRAME: begin
        // Frame: deselected idle, selected idle, start, four argument bytes, crc.
        case (cs.byte_count)
          BC_W'(0): xo.select = 1'b0;
          BC_W'(2): xo.mosi = FRAME_START | {2'b00, cs.index};
          BC_W'(3): xo.mosi = cs.arg[31:24];
          BC_W'(4): xo.mosi = cs.arg[23:16];
          BC_W'(5): xo.mosi = cs.arg[15:8];
          BC_W'(6): xo.mosi = cs.arg[7:0];
          BC_W'(7): xo.mosi = ((cs.index == CMD_GO_IDLE) ? CRC_GO_IDLE : CRC_OTHER)
                              | 8'h01;
          default: xo.mosi = BYTE_IDLE;
        endcase
      end
      default: begin
        xo.mosi = BYTE_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/sd_spi_init_and_block_read.sv =====
// SD card SPI host sequencer: card init and single block read.
// The result word of an accepted input word is registered in the output register, or in the skid stage.
// Throughput: one input word per cycle while the skid stage is empty; the state update is a single registered pass.
// An output register and a skid stage keep input accepted while one result waits.
// Synchronous active-low reset sets the idle phase and the register defaults.
`timescale 1ns / 1ps
`include "sd_spi_init_and_block_read_assert.svh"
module sd_spi_init_and_block_read
  import sdspi_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  sdspi_in_if.sink    in_ch,
  sdspi_out_if.source out_ch
);

  // Configuration registers.
  logic [7:0]  dummy_bytes_r, reset_attempts_r, init_attempts_r, response_polls_r;
  logic [15:0] token_polls_r;

  // Sequencer state.
  phase_t          phase_r, phase_nxt;
  logic            operation_r, operation_nxt;
  logic [BC_W-1:0] byte_count_r, byte_count_nxt;
  logic [15:0]     poll_count_r, poll_count_nxt;
  logic [7:0]      attempt_count_r, attempt_count_nxt;
  logic [5:0]      command_index_r, command_index_nxt;
  logic [31:0]     command_arg_r, command_arg_nxt;
  logic [7:0]      last_response_r, last_response_nxt;

  // Output register and skid stage.
  res_t out_r, out_nxt, skid_r, skid_nxt;
  logic out_valid_r, out_valid_nxt, skid_valid_r, skid_valid_nxt;

  logic       accept, push, pop;
  logic       has_res, issue_en, fin, dv;
  logic [1:0] st_code;
  res_t       res;
  cmd_state_t cs_nxt;
  xfer_t      xo;

  logic [BC_W-1:0] bc_inc;
  logic [7:0]      att_inc, reset_lim, init_lim;
  logic [8:0]      rsp_lim;
  logic [16:0]     tok_lim, poll_inc;

  assign accept   = in_ch.valid && in_ch.ready;
  assign push     = accept && has_res;
  assign pop      = out_valid_r && out_ch.ready;
  assign in_ch.ready = !skid_valid_r;

  assign bc_inc    = byte_count_r + BC_W'(1);
  assign att_inc   = attempt_count_r + 8'd1;
  assign poll_inc  = {1'b0, poll_count_r} + 17'd1;
  assign reset_lim = (reset_attempts_r == 8'd0) ? 8'd1 : reset_attempts_r;
  assign init_lim  = (init_attempts_r == 8'd0) ? 8'd1 : init_attempts_r;
  assign rsp_lim   = (response_polls_r == 8'd0) ? 9'd256 : {1'b0, response_polls_r};
  assign tok_lim   = (token_polls_r == 16'd0) ? 17'h10000 : {1'b0, token_polls_r};

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dummy_bytes_r    <= 8'd10;
      reset_attempts_r <= 8'd100;
      init_attempts_r  <= 8'd200;
      response_polls_r <= 8'd255;
      token_polls_r    <= 16'd65535;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DUMMY_BYTES:    dummy_bytes_r    <= cfg_data[7:0];
        CFG_RESET_ATTEMPTS: reset_attempts_r <= cfg_data[7:0];
        CFG_INIT_ATTEMPTS:  init_attempts_r  <= cfg_data[7:0];
        CFG_RESPONSE_POLLS: response_polls_r <= cfg_data[7:0];
        CFG_TOKEN_POLLS:    token_polls_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next state of the sequencer for the word at the input.
  always_comb begin
    phase_nxt         = phase_r;
    operation_nxt     = operation_r;
    byte_count_nxt    = byte_count_r;
    poll_count_nxt    = poll_count_r;
    attempt_count_nxt = attempt_count_r;
    command_index_nxt = command_index_r;
    command_arg_nxt   = command_arg_r;
    last_response_nxt = last_response_r;
    has_res = 1'b0;
    fin     = 1'b0;
    dv      = 1'b0;
    st_code = ST_OK;

    if (phase_r == PH_IDLE) begin
      if (in_ch.command == REQ_INIT) begin
        has_res           = 1'b1;
        operation_nxt     = 1'b0;
        attempt_count_nxt = 8'd0;
        last_response_nxt = BYTE_IDLE;
        phase_nxt         = PH_DUMMY;
        byte_count_nxt    = '0;
        poll_count_nxt    = 16'd0;
        if (dummy_bytes_r == 8'd0) begin
          phase_nxt         = PH_FRAME;
          command_index_nxt = CMD_GO_IDLE;
          command_arg_nxt   = 32'd0;
        end
      end else if (in_ch.command == REQ_READ) begin
        has_res           = 1'b1;
        operation_nxt     = 1'b1;
        attempt_count_nxt = 8'd0;
        last_response_nxt = BYTE_IDLE;
        phase_nxt         = PH_FRAME;
        byte_count_nxt    = '0;
        poll_count_nxt    = 16'd0;
        command_index_nxt = CMD_READ;
        command_arg_nxt   = {in_ch.lba, 9'd0};
      end
    end else if (in_ch.command == REQ_BYTE) begin
      has_res = 1'b1;
      case (phase_r)
        PH_DUMMY: begin
          byte_count_nxt = bc_inc;
          if (bc_inc >= BC_W'(dummy_bytes_r)) begin
            attempt_count_nxt = 8'd0;
            phase_nxt         = PH_FRAME;
            byte_count_nxt    = '0;
            poll_count_nxt    = 16'd0;
            command_index_nxt = CMD_GO_IDLE;
            command_arg_nxt   = 32'd0;
          end
        end
        PH_FRAME: begin
          byte_count_nxt = bc_inc;
          if (bc_inc >= FRAME_BYTES) begin
            phase_nxt      = PH_RESP;
            poll_count_nxt = 16'd0;
          end
        end
        PH_RESP: begin
          last_response_nxt = in_ch.miso;
          if (!in_ch.miso[7] || (poll_inc >= {8'd0, rsp_lim})) begin
            // Response in hand: decide on the next command.
            case (command_index_r)
              CMD_GO_IDLE: begin
                attempt_count_nxt = att_inc;
                if (in_ch.miso == 8'd1) begin
                  attempt_count_nxt = 8'd0;
                  phase_nxt         = PH_FRAME;
                  byte_count_nxt    = '0;
                  poll_count_nxt    = 16'd0;
                  command_index_nxt = CMD_APP;
                  command_arg_nxt   = 32'd0;
                end else if (att_inc >= reset_lim) begin
                  fin     = 1'b1;
                  st_code = ST_ERR;
                end else begin
                  phase_nxt      = PH_FRAME;
                  byte_count_nxt = '0;
                  poll_count_nxt = 16'd0;
                end
              end
              CMD_APP, CMD_OP_COND: begin
                if ((command_index_r == CMD_APP) && (in_ch.miso <= 8'd1)) begin
                  phase_nxt         = PH_FRAME;
                  byte_count_nxt    = '0;
                  poll_count_nxt    = 16'd0;
                  command_index_nxt = CMD_OP_COND;
                  command_arg_nxt   = 32'd0;
                end else begin
                  // End of one app-command attempt.
                  attempt_count_nxt = att_inc;
                  if ((in_ch.miso == 8'd0) || (att_inc >= init_lim)) begin
                    phase_nxt = PH_TAIL;
                  end else begin
                    phase_nxt         = PH_FRAME;
                    byte_count_nxt    = '0;
                    poll_count_nxt    = 16'd0;
                    command_index_nxt = CMD_APP;
                    command_arg_nxt   = 32'd0;
                  end
                end
              end
              CMD_BLOCKLEN: begin
                phase_nxt = PH_TAIL;
              end
              CMD_READ: begin
                if (in_ch.miso != 8'd0) begin
                  fin     = 1'b1;
                  st_code = ST_ERR;
                end else begin
                  phase_nxt      = PH_TOKEN;
                  poll_count_nxt = 16'd0;
                end
              end
              default: begin
                fin     = 1'b1;
                st_code = ST_ERR;
              end
            endcase
          end else begin
            poll_count_nxt = poll_inc[15:0];
          end
        end
        PH_TOKEN: begin
          if (in_ch.miso == TOKEN_START) begin
            phase_nxt      = PH_DATA;
            byte_count_nxt = '0;
          end else if (poll_inc >= tok_lim) begin
            fin     = 1'b1;
            st_code = ST_TIMEOUT;
          end else begin
            poll_count_nxt = poll_inc[15:0];
          end
        end
        PH_DATA: begin
          dv             = (byte_count_r < DATA_END);
          byte_count_nxt = bc_inc;
          if (bc_inc >= BLOCK_END) begin
            phase_nxt = PH_TAIL;
          end
        end
        PH_TAIL: begin
          if (operation_r) begin
            fin = 1'b1;
          end else if (command_index_r == CMD_BLOCKLEN) begin
            fin     = 1'b1;
            st_code = (last_response_r == 8'd0) ? ST_OK : ST_ERR;
          end else if (last_response_r != 8'd0) begin
            fin     = 1'b1;
            st_code = ST_ERR;
          end else begin
            phase_nxt         = PH_FRAME;
            byte_count_nxt    = '0;
            poll_count_nxt    = 16'd0;
            command_index_nxt = CMD_BLOCKLEN;
            command_arg_nxt   = BLOCKLEN_ARG;
          end
        end
        default: begin
          fin     = 1'b1;
          st_code = ST_ERR;
        end
      endcase
      if (fin) begin
        phase_nxt = PH_IDLE;
      end
    end
  end

  assign issue_en = has_res && !fin;

  assign cs_nxt.phase      = phase_nxt;
  assign cs_nxt.byte_count = byte_count_nxt;
  assign cs_nxt.index      = command_index_nxt;
  assign cs_nxt.arg        = command_arg_nxt;

  sdspi_frame_gen u_frame_gen (
    .cs (cs_nxt),
    .xo (xo)
  );

  // Result word; unused fields are zero.
  always_comb begin
    res            = '0;
    res.xfer       = issue_en;
    res.mosi       = issue_en ? xo.mosi : 8'd0;
    res.select     = issue_en && xo.select;
    res.data_valid = dv;
    res.data_byte  = dv ? in_ch.miso : 8'd0;
    res.done_res   = fin;
    res.status     = fin ? st_code : ST_OK;
  end

  // Output register with a skid stage behind it.
  always_comb begin
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (skid_valid_r) begin
      if (pop) begin
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_nxt       = res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = res;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_IDLE;
      operation_r     <= 1'b0;
      byte_count_r    <= '0;
      poll_count_r    <= 16'd0;
      attempt_count_r <= 8'd0;
      command_index_r <= 6'd0;
      command_arg_r   <= 32'd0;
      last_response_r <= BYTE_IDLE;
      out_valid_r     <= 1'b0;
      skid_valid_r    <= 1'b0;
    end else begin
      if (accept) begin
        phase_r         <= phase_nxt;
        operation_r     <= operation_nxt;
        byte_count_r    <= byte_count_nxt;
        poll_count_r    <= poll_count_nxt;
        attempt_count_r <= attempt_count_nxt;
        command_index_r <= command_index_nxt;
        command_arg_r   <= command_arg_nxt;
        last_response_r <= last_response_nxt;
      end
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.xfer       = out_r.xfer;
  assign out_ch.mosi       = out_r.mosi;
  assign out_ch.select     = out_r.select;
  assign out_ch.data_valid = out_r.data_valid;
  assign out_ch.data_byte  = out_r.data_byte;
  assign out_ch.done_res   = out_r.done_res;
  assign out_ch.status     = out_r.status;

  // Checks on the sequencer and the output buffer.
  `SDSPI_ASSERT_NOW(a_skid_behind_out, skid_valid_r, out_valid_r,
                    "skid stage holds a word while the output register is empty")
  `SDSPI_ASSERT_NOW(a_done_no_xfer, out_valid_r && out_r.done_res, !out_r.xfer,
                    "finish report also requests an exchange")
  `SDSPI_ASSERT_NOW(a_data_with_xfer, out_valid_r && out_r.data_valid, out_r.xfer,
                    "block data byte without a following exchange")
  `SDSPI_ASSERT_NEXT(a_done_to_idle, push && res.done_res, phase_r == PH_IDLE,
                     "sequencer not idle after a finish report")
  `SDSPI_ASSERT_NOW(a_data_count, phase_r == PH_DATA, byte_count_r < BLOCK_END,
                    "data byte count ran past the block and its crc")

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import sdspi_pkg::*;

  // Response and command codes used by the card emulation and the tracker.
  localparam logic [7:0] R1_READY   = 8'h00;
  localparam logic [7:0] R1_IDLE    = 8'h01;
  localparam logic [7:0] END_BIT    = 8'h01;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 950;
  localparam int DIRECTED_ITEMS = 25;

  // Tracks the sequencer state and the result words it must produce.
  class sd_host_model;
    logic [7:0]  n_dummy, max_reset_tries, max_init_tries, max_resp_polls;
    logic [15:0] max_token_polls;
    phase_t      phase_now;
    bit          read_op;
    logic [15:0] byte_ctr, poll_ctr;
    logic [7:0]  tries, last_r;
    logic [5:0]  cmd_idx;
    logic [31:0] cmd_arg;
    res_t        word;
    res_t        host_words[$];
    int          errors, checked, data_bytes;
    int          finishes[3];

    function new();
      n_dummy = 8'd10;
      max_reset_tries = 8'd100;
      max_init_tries = 8'd200;
      max_resp_polls = 8'd255;
      max_token_polls = 16'd65535;
      phase_now = PH_IDLE;
      read_op = 1'b0;
      byte_ctr = '0;
      poll_ctr = '0;
      tries = '0;
      cmd_idx = '0;
      cmd_arg = '0;
      last_r = BYTE_IDLE;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] v);
      case (idx)
        CFG_DUMMY_BYTES:    n_dummy = v[7:0];
        CFG_RESET_ATTEMPTS: max_reset_tries = v[7:0];
        CFG_INIT_ATTEMPTS:  max_init_tries = v[7:0];
        CFG_RESPONSE_POLLS: max_resp_polls = v[7:0];
        CFG_TOKEN_POLLS:    max_token_polls = v;
        default: ;
      endcase
    endfunction

    function void begin_command(logic [5:0] idx, logic [31:0] arg);
      cmd_idx = idx;
      cmd_arg = arg;
      phase_now = PH_FRAME;
      byte_ctr = '0;
      poll_ctr = '0;
    endfunction

    // The exchange that the current phase and byte position ask for.
    function void emit_exchange();
      int sh;
      word.xfer = 1'b1;
      word.mosi = BYTE_IDLE;
      word.select = 1'b1;
      case (phase_now)
        PH_DUMMY, PH_TAIL: word.select = 1'b0;
        PH_FRAME: begin
          if (byte_ctr == 0) begin
            word.select = 1'b0;
          end else if (byte_ctr == 2) begin
            word.mosi = FRAME_START | {2'b00, cmd_idx};
          end else if (byte_ctr >= 3 && byte_ctr <= 6) begin
            // Argument goes out most significant byte first.
            sh = 8 * (6 - int'(byte_ctr));
            word.mosi = cmd_arg[sh +: 8];
          end else if (byte_ctr == 7) begin
            word.mosi = ((cmd_idx == CMD_GO_IDLE) ? CRC_GO_IDLE : CRC_OTHER) | END_BIT;
          end
        end
        default: ;
      endcase
    endfunction

    // End of one CMD55 plus ACMD41 attempt.
    function int finish_acmd(logic [7:0] r);
      logic [7:0] lim;
      lim = (max_init_tries == 0) ? 8'd1 : max_init_tries;
      tries++;
      if (r == R1_READY || tries >= lim) begin
        last_r = r;
        phase_now = PH_TAIL;
      end else begin
        begin_command(CMD_APP, '0);
      end
      return -1;
    endfunction

    // Consumes the returned byte; gives a finish status or -1 to go on.
    function int consume_byte(logic [7:0] miso);
      int lim;
      case (phase_now)
        PH_DUMMY: begin
          byte_ctr++;
          if (byte_ctr >= n_dummy) begin
            tries = '0;
            begin_command(CMD_GO_IDLE, '0);
          end
          return -1;
        end
        PH_FRAME: begin
          byte_ctr++;
          if (byte_ctr >= FRAME_BYTES) begin
            phase_now = PH_RESP;
            poll_ctr = '0;
          end
          return -1;
        end
        PH_RESP: begin
          last_r = miso;
          lim = (max_resp_polls == 0) ? 256 : int'(max_resp_polls);
          if (miso[7] && int'(poll_ctr) + 1 < lim) begin
            poll_ctr++;
            return -1;
          end
          // A response arrived, or polling ran out.
          case (cmd_idx)
            CMD_GO_IDLE: begin
              tries++;
              if (miso == R1_IDLE) begin
                tries = '0;
                begin_command(CMD_APP, '0);
                return -1;
              end
              if (tries >= ((max_reset_tries == 0) ? 8'd1 : max_reset_tries)) return ST_ERR;
              begin_command(CMD_GO_IDLE, '0);
              return -1;
            end
            CMD_APP: begin
              if (miso > R1_IDLE) return finish_acmd(miso);
              begin_command(CMD_OP_COND, '0);
              return -1;
            end
            CMD_OP_COND: return finish_acmd(miso);
            CMD_BLOCKLEN: begin
              phase_now = PH_TAIL;
              return -1;
            end
            CMD_READ: begin
              if (miso != R1_READY) return ST_ERR;
              phase_now = PH_TOKEN;
              poll_ctr = '0;
              return -1;
            end
            default: return ST_ERR;
          endcase
        end
        PH_TOKEN: begin
          if (miso == TOKEN_START) begin
            phase_now = PH_DATA;
            byte_ctr = '0;
            return -1;
          end
          lim = (max_token_polls == 0) ? 65536 : int'(max_token_polls);
          if (int'(poll_ctr) + 1 >= lim) return ST_TIMEOUT;
          poll_ctr++;
          return -1;
        end
        PH_DATA: begin
          // The two CRC bytes after the block are dropped.
          if (byte_ctr < BLOCK_BYTES) begin
            word.data_valid = 1'b1;
            word.data_byte = miso;
          end
          byte_ctr++;
          if (byte_ctr >= BLOCK_END) phase_now = PH_TAIL;
          return -1;
        end
        PH_TAIL: begin
          if (read_op) return ST_OK;
          if (cmd_idx == CMD_BLOCKLEN) return (last_r == R1_READY) ? ST_OK : ST_ERR;
          if (last_r != R1_READY) return ST_ERR;
          begin_command(CMD_BLOCKLEN, BLOCKLEN_ARG);
          return -1;
        end
        default: return ST_ERR;
      endcase
    endfunction

    // Notes one accepted input word; returns 1 when it causes a result word.
    function bit note_word(logic [1:0] cmd, logic [22:0] lba, logic [7:0] miso);
      int st;
      word = '0;
      if (phase_now == PH_IDLE) begin
        if (cmd == REQ_INIT) begin
          read_op = 1'b0;
          tries = '0;
          last_r = BYTE_IDLE;
          phase_now = PH_DUMMY;
          byte_ctr = '0;
          poll_ctr = '0;
          if (n_dummy == 0) begin_command(CMD_GO_IDLE, '0);
        end else if (cmd == REQ_READ) begin
          read_op = 1'b1;
          tries = '0;
          last_r = BYTE_IDLE;
          // Byte address of the block.
          begin_command(CMD_READ, {lba, 9'b0});
        end else begin
          return 1'b0;
        end
        emit_exchange();
        host_words.push_back(word);
        return 1'b1;
      end
      // Starts while busy and the unused command are dropped.
      if (cmd != REQ_BYTE) return 1'b0;
      st = consume_byte(miso);
      if (st >= 0) begin
        phase_now = PH_IDLE;
        word.done_res = 1'b1;
        word.status = st[1:0];
      end else begin
        emit_exchange();
      end
      host_words.push_back(word);
      return 1'b1;
    endfunction

    function void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    // Compares an accepted result word with the oldest outstanding one.
    function void check_word(res_t got);
      res_t want;
      if (host_words.size() == 0) begin
        $error("result word arrived with none outstanding");
        errors++;
        return;
      end
      want = host_words.pop_front();
      checked++;
      if (want.data_valid) data_bytes++;
      if (want.done_res) finishes[want.status]++;
      check_field("xfer", 8'(want.xfer), 8'(got.xfer));
      check_field("mosi", want.mosi, got.mosi);
      check_field("select", 8'(want.select), 8'(got.select));
      check_field("data_valid", 8'(want.data_valid), 8'(got.data_valid));
      check_field("data_byte", want.data_byte, got.data_byte);
      check_field("done_res", 8'(want.done_res), 8'(got.done_res));
      check_field("status", 8'(want.status), 8'(got.status));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  sdspi_in_if  in_ch();
  sdspi_out_if out_ch();

  sd_spi_init_and_block_read dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  sd_host_model host;
  bit     in_took;
  bit     quiet;
  bit     mute;
  bit     silent;
  phase_t seen_phase;
  int     items_done;
  int     setting;

  always #10 clk = ~clk;

  // Safety net against a hung handshake.
  initial begin
    #10_000_000;
    $display("sd_spi_init_and_block_read: mismatch");
    $finish;
  end

  // One clock: check the result word, note the input word, pick the stall.
  task automatic tick();
    res_t got;
    @(posedge clk);
    in_took = 1'b0;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.xfer, out_ch.mosi, out_ch.select, out_ch.data_valid,
                out_ch.data_byte, out_ch.done_res, out_ch.status};
        host.check_word(got);
      end
      if (in_ch.valid && in_ch.ready) begin
        in_took = 1'b1;
        if (host.note_word(in_ch.command, in_ch.lba, in_ch.miso)) items_done++;
      end
    end
    quiet = (items_done >= 400 && items_done < 700);
    out_ch.ready <= quiet || ($urandom_range(0, 99) >= 8);
  endtask

  // Offers one input word, with an occasional gap before it.
  task automatic send_word(input logic [1:0] cmd, input logic [22:0] lba,
                           input logic [7:0] miso);
    int gap;
    gap = (!quiet && $urandom_range(0, 99) < 3) ? $urandom_range(1, 4) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) tick();
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.lba <= lba;
    in_ch.miso <= miso;
    do tick(); while (!in_took);
  endtask

  // Waits until the block is idle and every result word has come.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (host.host_words.size() != 0 || host.phase_now != PH_IDLE) tick();
    repeat (4) tick();
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    tick();
    host.set_reg(idx, v);
  endtask

  // Random limit for an 8-bit register; the upper byte is don't-care.
  function automatic logic [15:0] byte_limit();
    logic [7:0] hi, lo;
    hi = 8'($urandom_range(0, 255));
    lo = 8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6));
    return {hi, lo};
  endfunction

  // Extremes first, then random settings.
  task automatic set_registers(input int which);
    logic [15:0] d, ra, ia, rp, tp;
    case (which)
      0: begin
        d = 16'h00FF; ra = 16'h00FF; ia = 16'h00FF; rp = 16'h00FF; tp = 16'hFFFF;
      end
      1: begin
        d = '0; ra = '0; ia = '0; rp = '0; tp = '0;
      end
      2: begin
        d = 16'd1; ra = 16'd1; ia = 16'd1; rp = 16'd1; tp = 16'd1;
      end
      default: begin
        d = byte_limit();
        ra = byte_limit();
        ia = byte_limit();
        rp = byte_limit();
        tp = 16'(($urandom_range(0, 1) != 0) ? $urandom_range(1, 64)
                                             : $urandom_range(0, 65535));
      end
    endcase
    wait_idle();
    write_reg(CFG_DUMMY_BYTES, d);
    write_reg(CFG_RESET_ATTEMPTS, ra);
    write_reg(CFG_INIT_ATTEMPTS, ia);
    write_reg(CFG_RESPONSE_POLLS, rp);
    write_reg(CFG_TOKEN_POLLS, tp);
    cfg_we <= 1'b0;
  endtask

  // Plays the card: answers the pending exchange, sometimes with noise.
  task automatic answer_card();
    logic [7:0] b;
    logic [1:0] c;
    if ($urandom_range(0, 99) < 3) begin
      case ($urandom_range(0, 2))
        0: c = REQ_INIT;
        1: c = REQ_READ;
        default: c = REQ_UNUSED;
      endcase
      send_word(c, 23'($urandom_range(0, 23'h7FFFFF)), 8'($urandom_range(0, 255)));
      return;
    end
    // A card that never answers a command, or never sends the token.
    if (host.phase_now != seen_phase) begin
      if (host.phase_now == PH_RESP) mute = ($urandom_range(0, 19) == 0);
      if (host.phase_now == PH_TOKEN)
        silent = host.max_token_polls != 0 && host.max_token_polls <= 64 &&
                 $urandom_range(0, 2) == 0;
      seen_phase = host.phase_now;
    end
    case (host.phase_now)
      PH_RESP: begin
        if (mute || $urandom_range(0, 99) < 30) begin
          b = 8'h80 | 8'($urandom_range(0, 127));
        end else begin
          case (host.cmd_idx)
            CMD_GO_IDLE: begin
              case ($urandom_range(0, 9))
                0: b = R1_READY;
                1: b = 8'($urandom_range(2, 127));
                2: b = 8'h05;
                default: b = R1_IDLE;
              endcase
            end
            CMD_APP:
              b = 8'(($urandom_range(0, 99) < 85) ? $urandom_range(0, 1)
                                                   : $urandom_range(2, 127));
            CMD_OP_COND: begin
              case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7: b = R1_READY;
                8, 9, 10: b = 8'($urandom_range(2, 127));
                default: b = R1_IDLE;
              endcase
            end
            CMD_BLOCKLEN:
              b = ($urandom_range(0, 99) < 90) ? R1_READY : 8'($urandom_range(1, 127));
            default:
              b = ($urandom_range(0, 99) < 85) ? R1_READY : 8'($urandom_range(1, 127));
          endcase
        end
      end
      PH_TOKEN: begin
        if (!silent && $urandom_range(0, 3) == 0) begin
          b = TOKEN_START;
        end else begin
          b = ($urandom_range(0, 99) < 70) ? BYTE_IDLE : 8'($urandom_range(0, 255));
          if (b == TOKEN_START) b = BYTE_IDLE;
        end
      end
      PH_DATA: b = 8'($urandom_range(0, 255));
      default: b = ($urandom_range(0, 3) != 0) ? BYTE_IDLE : 8'($urandom_range(0, 255));
    endcase
    send_word(REQ_BYTE, 23'($urandom_range(0, 23'h7FFFFF)), b);
  endtask

  // One init or block read from start to finish.
  task automatic run_operation();
    logic [22:0] lba;
    if ($urandom_range(0, 9) == 0)
      send_word(($urandom_range(0, 1) != 0) ? REQ_BYTE : REQ_UNUSED,
                23'($urandom_range(0, 23'h7FFFFF)), 8'($urandom_range(0, 255)));
    case ($urandom_range(0, 4))
      0: lba = '0;
      1: lba = '1;
      default: lba = 23'($urandom_range(0, 23'h7FFFFF));
    endcase
    send_word(($urandom_range(0, 1) != 0) ? REQ_INIT : REQ_READ, lba,
              8'($urandom_range(0, 255)));
    while (host.phase_now != PH_IDLE) answer_card();
  endtask

  initial begin
    host = new();
    seen_phase = PH_IDLE;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_DUMMY_BYTES;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.command <= REQ_BYTE;
    in_ch.lba <= '0;
    in_ch.miso <= '0;
    out_ch.ready <= 1'b0;
    repeat (10) tick();
    rst_n <= 1'b1;
    tick();

    // While idle, a returned byte and the unused command are dropped.
    send_word(REQ_BYTE, '0, 8'h00);
    send_word(REQ_UNUSED, '1, BYTE_IDLE);

    // Read before init at the top block number, with starts while busy,
    // ending on a rejected CMD17.
    send_word(REQ_READ, '1, 8'h00);
    for (int i = 0; i < 8; i++) begin
      send_word(REQ_BYTE, '1, (i % 2 != 0) ? BYTE_IDLE : 8'h00);
      if (i == 3) begin
        send_word(REQ_INIT, '0, 8'h00);
        send_word(REQ_READ, '0, BYTE_IDLE);
        send_word(REQ_UNUSED, '1, 8'h00);
      end
    end
    send_word(REQ_BYTE, '0, 8'h05);

    // No dummy bytes and a zero CMD0 limit: one attempt, no idle answer.
    wait_idle();
    write_reg(CFG_DUMMY_BYTES, '0);
    write_reg(CFG_RESET_ATTEMPTS, '0);
    cfg_we <= 1'b0;
    send_word(REQ_INIT, '0, BYTE_IDLE);
    repeat (8) send_word(REQ_BYTE, '0, 8'($urandom_range(0, 255)));
    send_word(REQ_BYTE, '0, R1_READY);

    // Random operations over a series of register settings.
    setting = 0;
    while (items_done < DIRECTED_ITEMS + RANDOM_ITEMS) begin
      set_registers(setting);
      setting++;
      repeat ($urandom_range(1, 3)) begin
        if (items_done < DIRECTED_ITEMS + RANDOM_ITEMS) run_operation();
      end
    end
    wait_idle();
    repeat (8) tick();

    $display("Covered %0d input words over %0d register settings; %0d result words checked.",
             items_done, setting, host.checked);
    $display("Finishes ok/error/timeout: %0d/%0d/%0d; %0d block data bytes delivered.",
             host.finishes[ST_OK], host.finishes[ST_ERR], host.finishes[ST_TIMEOUT],
             host.data_bytes);
    if (host.errors == 0 && host.host_words.size() == 0) begin
      $display("sd_spi_init_and_block_read: match");
    end else begin
      $display("sd_spi_init_and_block_read: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/sdspi_pkg.sv
rtl/sdspi_if.sv
rtl/sdspi_frame_gen.sv
rtl/sd_spi_init_and_block_read.sv
bench/tb_top.sv
